// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands sampled on clk and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfp assertion failed");

// next-cycle implication
`define RFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfp assertion failed");

`endif

// ----- rtl/rfp_pkg.sv -----
// ---------------------------------------------------------------------------
// rfp_pkg
// Shared sizes, request and status codes and stage records of the ring fifo.
// ---------------------------------------------------------------------------
package rfp_pkg;

  localparam int DEPTH          = 16;
  localparam int ADDR_W         = $clog2(DEPTH);
  localparam int CNT_W          = ADDR_W + 1;
  localparam int LOG2_W         = 3;
  localparam int MAX_LOG2       = ADDR_W;
  localparam int CAP_LOG2_RST   = 4;
  localparam int REQ_W          = 2;
  localparam int IDX_W          = 4;
  localparam int STS_W          = 2;
  localparam int WORD_WIDTH_DEF = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_COUNT = 2'd3
  } req_e_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_e_t;

  // one ram access per request at most
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
  } mem_cmd_t;

  // everything of a result except the word read from the ram
  typedef struct packed {
    status_e_t        status;
    logic [CNT_W-1:0] fill_count;
    logic             is_empty;
    logic             has_data;
  } res_info_t;

endpackage

// ----- rtl/rfp_mem.sv -----
// ---------------------------------------------------------------------------
// rfp_mem
// Entry store: single-port synchronous ram, registered read data.
// ---------------------------------------------------------------------------
module rfp_mem #(
  parameter int WORD_WIDTH = rfp_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  rfp_pkg::mem_cmd_t     cmd,
  input  logic [WORD_WIDTH-1:0] wdata,
  output logic [WORD_WIDTH-1:0] rdata
);
  import rfp_pkg::*;

  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.addr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (cmd.re) begin
      rdata_r <= mem[cmd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rfp_ctrl.sv -----
// ---------------------------------------------------------------------------
// rfp_ctrl
// Head pointer, fill count and capacity register; decodes each request,
// issues the ram access and builds the result record.
// ---------------------------------------------------------------------------
module rfp_ctrl #(
  parameter int WORD_WIDTH = rfp_pkg::WORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [rfp_pkg::LOG2_W-1:0] cfg_wdata,
  input  logic                       acc,
  input  logic [rfp_pkg::REQ_W-1:0]  req_type,
  input  logic [WORD_WIDTH-1:0]      push_data,
  input  logic [rfp_pkg::IDX_W-1:0]  peek_index,
  output rfp_pkg::mem_cmd_t          mem_cmd,
  output logic [WORD_WIDTH-1:0]      mem_wdata,
  output rfp_pkg::res_info_t         res
);
  import rfp_pkg::*;

  logic [LOG2_W-1:0] cap_log2_r;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic [LOG2_W-1:0] eff_log2;
  logic [CNT_W-1:0]  cap;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] pos;
  req_e_t            req;
  status_e_t         status;
  logic              we, re;

  // capacity never exceeds the ram depth
  assign eff_log2 = (cap_log2_r > LOG2_W'(MAX_LOG2)) ? LOG2_W'(MAX_LOG2) : cap_log2_r;
  assign cap      = CNT_W'(1) << eff_log2;
  assign mask     = ADDR_W'(cap - CNT_W'(1));
  assign req      = req_e_t'(req_type);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    status    = ST_OK;
    pos       = head_r & mask;
    we        = 1'b0;
    re        = 1'b0;
    case (req)
      REQ_PUSH: begin
        pos = (head_r + count_r[ADDR_W-1:0]) & mask;
        if (count_r >= cap) begin
          status = ST_FULL;
        end else begin
          we        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_POP: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else begin
          re        = 1'b1;
          head_nxt  = (pos + ADDR_W'(1)) & mask;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_PEEK: begin
        pos = (head_r + ADDR_W'(peek_index)) & mask;
        if (CNT_W'(peek_index) >= count_r) begin
          status = ST_BADIDX;
        end else begin
          re = 1'b1;
        end
      end
      REQ_COUNT: begin
        status = ST_OK;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_log2_r <= LOG2_W'(CAP_LOG2_RST);
      head_r     <= '0;
      count_r    <= '0;
    end else begin
      if (cfg_we) begin
        cap_log2_r <= cfg_wdata;
      end
      if (acc) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
    end
  end

  assign mem_cmd.we   = acc && we;
  assign mem_cmd.re   = acc && re;
  assign mem_cmd.addr = pos;
  assign mem_wdata    = push_data;

  assign res.status     = status;
  assign res.fill_count = count_nxt;
  assign res.is_empty   = (count_nxt == '0);
  assign res.has_data   = re;

endmodule

// ----- rtl/rfp_resp.sv -----
// ---------------------------------------------------------------------------
// rfp_resp
// Result pipe: a read stage that waits on the ram, then the output register.
// ---------------------------------------------------------------------------
module rfp_resp #(
  parameter int WORD_WIDTH = rfp_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  rfp_pkg::res_info_t    res,
  input  logic [WORD_WIDTH-1:0] rdata,
  input  logic                  out_tready,
  output logic                  in_ready,
  output logic                  s1_busy,
  output logic                  out_valid,
  output rfp_pkg::res_info_t    out_res,
  output logic [WORD_WIDTH-1:0] out_data
);
  import rfp_pkg::*;

  logic                  s1_valid_r, s1_valid_nxt;
  res_info_t             s1_res_r;
  logic                  out_valid_r, out_valid_nxt;
  res_info_t             out_res_r;
  logic [WORD_WIDTH-1:0] out_data_r;
  logic                  adv;

  assign adv      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_ready = !s1_valid_r || adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_r <= res;
    end
    if (adv) begin
      out_res_r  <= s1_res_r;
      // ram data is stable while the read stage holds
      out_data_r <= s1_res_r.has_data ? rdata : '0;
    end
  end

  assign s1_busy   = s1_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/ring_fifo_with_peek.sv -----
// ---------------------------------------------------------------------------
// ring_fifo_with_peek
// Circular fifo with push, pop, peek and count requests.
// ---------------------------------------------------------------------------
// One request is taken per clock while in_tready is high. The synchronous
// entry ram read and the read stage load at the edge that takes the request,
// and the output register loads the result when the read stage advances. A
// read stage and the output register let one more request in while a result
// waits on out_tready. in_tready is held low during reset. Head pointer and
// fill count update at the edge that takes the request, so back-to-back
// requests see each other. The entry ram is not cleared after reset; only
// written slots are ever read in normal use. cfg_wdata sets log2 of the
// capacity in use, capped at log2 of the ram depth; write it only while the
// block is idle.
`include "assert_macros.svh"

module ring_fifo_with_peek #(
  parameter int  WORD_WIDTH  = rfp_pkg::WORD_WIDTH_DEF,
  localparam int IN_TDATA_W  = ((rfp_pkg::REQ_W + WORD_WIDTH + rfp_pkg::IDX_W + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((rfp_pkg::STS_W + WORD_WIDTH + rfp_pkg::CNT_W + 1 + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [rfp_pkg::LOG2_W-1:0] cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // req_type, push_data, peek_index, zero pad
  input  logic [IN_TDATA_W-1:0]      in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // status, read_data, fill_count, is_empty, zero pad
  output logic [OUT_TDATA_W-1:0]     out_tdata
);
  import rfp_pkg::*;

  localparam int DATA_LO = REQ_W;
  localparam int IDX_LO  = REQ_W + WORD_WIDTH;

  logic                  acc;
  logic                  in_ready;
  logic                  s1_busy;
  mem_cmd_t              mem_cmd;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic [WORD_WIDTH-1:0] mem_rdata;
  res_info_t             res;
  res_info_t             out_res;
  logic [WORD_WIDTH-1:0] out_data;

  assign in_tready = in_ready && rst_n;
  assign acc       = in_tvalid && in_tready;

  rfp_ctrl #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .acc        (acc),
    .req_type   (in_tdata[REQ_W-1:0]),
    .push_data  (in_tdata[DATA_LO +: WORD_WIDTH]),
    .peek_index (in_tdata[IDX_LO +: IDX_W]),
    .mem_cmd    (mem_cmd),
    .mem_wdata  (mem_wdata),
    .res        (res)
  );

  rfp_mem #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  rfp_resp #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_resp (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .res        (res),
    .rdata      (mem_rdata),
    .out_tready (out_tready),
    .in_ready   (in_ready),
    .s1_busy    (s1_busy),
    .out_valid  (out_tvalid),
    .out_res    (out_res),
    .out_data   (out_data)
  );

  assign out_tdata = OUT_TDATA_W'({out_res.is_empty, out_res.fill_count, out_data,
                                   out_res.status});

  // a taken request always occupies the read stage next cycle
  `RFP_ASSERT_NXT(a_take_fills_stage, acc, s1_busy)
  // both stages full and output stalled: no request may be taken
  `RFP_ASSERT_IMP(a_full_pipe_stalls, s1_busy && out_tvalid && !out_tready, !in_tready)
  // refused results (status not ok) carry a zero word
  `RFP_ASSERT_IMP(a_no_data_zero, out_tvalid && out_res.status != ST_OK,
                  out_tdata[STS_W +: WORD_WIDTH] == '0)
  // the fill count never exceeds the ram depth
  `RFP_ASSERT_IMP(a_count_bound, out_tvalid,
                  out_tdata[STS_W + WORD_WIDTH +: CNT_W] <= CNT_W'(DEPTH))

endmodule

// ----- sim/ring_fifo_with_peek_test.sv -----
// ---------------------------------------------------------------------------
// ring_fifo_with_peek_test
// Self-checking bench for the ring fifo: a mirror of the fifo state predicts
// status, read word, fill count and empty flag of every request. Directed
// cases and biased random traffic run over all capacity settings and several
// idle/stall mixes, including a long output stall that backs up the input.
// ---------------------------------------------------------------------------
module ring_fifo_with_peek_test;
  import rfp_pkg::*;

  localparam int WORD_W     = WORD_WIDTH_DEF;
  localparam int IN_W       = ((REQ_W + WORD_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_W      = ((STS_W + WORD_W + CNT_W + 1 + 7) / 8) * 8;
  localparam int DATA_LSB   = STS_W;
  localparam int FILL_LSB   = STS_W + WORD_W;
  localparam int EMPTY_BIT  = FILL_LSB + CNT_W;
  localparam int QUIET_MAX  = 2000;

  typedef struct packed {
    status_e_t         status;
    logic [WORD_W-1:0] data;
    logic [CNT_W-1:0]  fill;
    logic              empty;
  } fifo_result_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [LOG2_W-1:0]   cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;

  // mirror of the fifo contents and pointers
  logic [WORD_W-1:0]   fifo_store [DEPTH];
  logic                slot_written [DEPTH];
  logic [ADDR_W-1:0]   fifo_head;
  logic [CNT_W-1:0]    fifo_count;
  logic [LOG2_W-1:0]   fifo_cap_log2;

  fifo_result_t        expected_results [$];
  fifo_result_t        seen_result;
  fifo_result_t        want_result;

  int                  send_idle_pct;
  int                  rx_stall_pct;
  int                  rx_hold_cycles;
  int                  quiet_cycles;
  int                  fail_count;
  int                  requests_sent;
  int                  results_checked;
  int                  status_seen [4];

  ring_fifo_with_peek uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int capacity_in_use();
    if (fifo_cap_log2 >= MAX_LOG2) begin
      return DEPTH;
    end
    return 1 << fifo_cap_log2;
  endfunction

  // a pop or peek that would land on a slot the ram never got
  function automatic bit reads_unwritten(req_e_t kind, logic [IDX_W-1:0] idx);
    int mask;
    mask = capacity_in_use() - 1;
    if (kind == REQ_POP && fifo_count != 0) begin
      return !slot_written[int'(fifo_head) & mask];
    end
    if (kind == REQ_PEEK && idx < fifo_count) begin
      return !slot_written[(int'(fifo_head) + int'(idx)) & mask];
    end
    return 1'b0;
  endfunction

  function automatic fifo_result_t apply_request(req_e_t kind, logic [WORD_W-1:0] word,
                                                 logic [IDX_W-1:0] idx);
    fifo_result_t res;
    int mask;
    int pos;
    mask = capacity_in_use() - 1;
    res.status = ST_OK;
    res.data = '0;
    case (kind)
      REQ_PUSH: begin
        if (fifo_count >= capacity_in_use()) begin
          res.status = ST_FULL;
        end else begin
          pos = (int'(fifo_head) + int'(fifo_count)) & mask;
          fifo_store[pos] = word;
          slot_written[pos] = 1'b1;
          fifo_count = fifo_count + 1'b1;
        end
      end
      REQ_POP: begin
        if (fifo_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          pos = int'(fifo_head) & mask;
          res.data = fifo_store[pos];
          fifo_head = ADDR_W'((pos + 1) & mask);
          fifo_count = fifo_count - 1'b1;
        end
      end
      REQ_PEEK: begin
        if (idx >= fifo_count) begin
          res.status = ST_BADIDX;
        end else begin
          res.data = fifo_store[(int'(fifo_head) + int'(idx)) & mask];
        end
      end
      default: ;
    endcase
    res.fill = fifo_count;
    res.empty = (fifo_count == 0);
    return res;
  endfunction

  task automatic send_request(req_e_t kind, logic [WORD_W-1:0] word, logic [IDX_W-1:0] idx);
    logic [IN_W-1:0] packed_req;
    req_e_t          sent_kind;
    sent_kind = kind;
    if (reads_unwritten(kind, idx)) begin
      sent_kind = REQ_COUNT;
    end
    packed_req = '0;
    packed_req[REQ_W-1:0] = sent_kind;
    packed_req[REQ_W +: WORD_W] = word;
    packed_req[REQ_W + WORD_W +: IDX_W] = idx;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    expected_results.push_back(apply_request(sent_kind, word, idx));
    in_tdata <= packed_req;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  // always waits for a clock edge before returning, so back-to-back calls drive in separate steps
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_capacity(logic [LOG2_W-1:0] log2_value);
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_wdata <= log2_value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    fifo_cap_log2 = log2_value;
  endtask

  // push-heavy and pop-heavy stretches so the fifo swings between empty and full
  task automatic pick_request(int n, output req_e_t kind, output logic [WORD_W-1:0] word,
                              output logic [IDX_W-1:0] idx);
    int r;
    int fill_trend;
    r = $urandom_range(99);
    fill_trend = ((n / 30) % 2 == 0);
    if (fill_trend ? (r < 55) : (r < 20)) begin
      kind = REQ_PUSH;
    end else if (fill_trend ? (r < 75) : (r < 60)) begin
      kind = REQ_POP;
    end else if (r < 92) begin
      kind = REQ_PEEK;
    end else begin
      kind = REQ_COUNT;
    end
    case ($urandom_range(7))
      0: word = '0;
      1: word = '1;
      default: word = $urandom;
    endcase
    if (fifo_count != 0 && $urandom_range(9) != 0) begin
      idx = IDX_W'($urandom_range(int'(fifo_count) - 1));
    end else begin
      idx = IDX_W'($urandom_range(DEPTH - 1));
    end
  endtask

  task automatic test_after_reset();
    send_request(REQ_COUNT, 32'hFFFF_FFFF, 4'hF);
    send_request(REQ_POP, 32'h0, 4'h0);
    send_request(REQ_PEEK, 32'h1234_5678, 4'h0);
    wait_drained();
  endtask

  task automatic test_fill_and_empty();
    write_capacity(3'd2);
    send_request(REQ_PUSH, 32'h0000_0000, 4'h0);
    send_request(REQ_PUSH, 32'hFFFF_FFFF, 4'hF);
    send_request(REQ_PUSH, 32'h5555_5555, 4'h5);
    send_request(REQ_PUSH, 32'hAAAA_AAAA, 4'hA);
    send_request(REQ_PUSH, 32'hDEAD_BEEF, 4'h0);
    send_request(REQ_PEEK, 32'h0, 4'h0);
    send_request(REQ_PEEK, 32'h0, 4'h3);
    send_request(REQ_PEEK, 32'h0, 4'hF);
    repeat (4) send_request(REQ_POP, 32'h0, 4'h0);
    send_request(REQ_POP, 32'h0, 4'h0);
    wait_drained();
  endtask

  // shrink and grow the capacity while words are held
  task automatic test_capacity_change();
    write_capacity(3'd1);
    send_request(REQ_PUSH, 32'h1111_1111, 4'h0);
    send_request(REQ_PUSH, 32'h2222_2222, 4'h0);
    send_request(REQ_PUSH, 32'h3333_3333, 4'h0);
    write_capacity(3'd0);
    send_request(REQ_PUSH, 32'h4444_4444, 4'h0);
    send_request(REQ_PEEK, 32'h0, 4'h0);
    send_request(REQ_POP, 32'h0, 4'h0);
    send_request(REQ_PEEK, 32'h0, 4'h0);
    write_capacity(3'd5);
    send_request(REQ_PUSH, 32'h8000_0001, 4'h0);
    send_request(REQ_PEEK, 32'h0, 4'h1);
    repeat (3) send_request(REQ_POP, 32'h0, 4'h0);
    wait_drained();
  endtask

  task automatic test_random_traffic(logic [LOG2_W-1:0] log2_value, int send_pct, int rx_pct,
                                     int count);
    req_e_t            kind;
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  idx;
    write_capacity(log2_value);
    send_idle_pct = send_pct;
    rx_stall_pct = rx_pct;
    for (int n = 0; n < count; n++) begin
      pick_request(n, kind, word, idx);
      send_request(kind, word, idx);
    end
    wait_drained();
  endtask

  // receiver holds off while requests keep coming, so the input has to stall
  task automatic test_output_backpressure();
    req_e_t            kind;
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  idx;
    send_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_cycles = 60;
    for (int n = 0; n < 20; n++) begin
      pick_request(n, kind, word, idx);
      send_request(kind, word, idx);
    end
    wait_drained();
  endtask

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_result.status = status_e_t'(out_tdata[STS_W-1:0]);
      seen_result.data = out_tdata[DATA_LSB +: WORD_W];
      seen_result.fill = out_tdata[FILL_LSB +: CNT_W];
      seen_result.empty = out_tdata[EMPTY_BIT];
      results_checked++;
      status_seen[int'(seen_result.status)]++;
      if (expected_results.size() == 0) begin
        $error("result with nothing outstanding: tdata %h", out_tdata);
        fail_count++;
      end else begin
        want_result = expected_results.pop_front();
        if (seen_result.status !== want_result.status) begin
          $error("status: expected %0d, got %0d", want_result.status, seen_result.status);
          fail_count++;
        end
        if (seen_result.data !== want_result.data) begin
          $error("read_data: expected %h, got %h", want_result.data, seen_result.data);
          fail_count++;
        end
        if (seen_result.fill !== want_result.fill) begin
          $error("fill_count: expected %0d, got %0d", want_result.fill, seen_result.fill);
          fail_count++;
        end
        if (seen_result.empty !== want_result.empty) begin
          $error("is_empty: expected %0d, got %0d", want_result.empty, seen_result.empty);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_MAX) begin
      $display("ring_fifo_with_peek_test: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    fifo_head = '0;
    fifo_count = '0;
    fifo_cap_log2 = LOG2_W'(CAP_LOG2_RST);
    for (int i = 0; i < DEPTH; i++) begin
      fifo_store[i] = '0;
      slot_written[i] = 1'b0;
    end
    send_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_cycles = 0;
    quiet_cycles = 0;
    fail_count = 0;
    requests_sent = 0;
    results_checked = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_fill_and_empty();
    test_capacity_change();
    test_random_traffic(3'd7, 0, 0, 130);
    test_random_traffic(3'd1, 50, 0, 130);
    test_random_traffic(3'd4, 0, 50, 130);
    test_random_traffic(3'd3, 22, 22, 100);
    test_random_traffic(3'd6, 22, 22, 30);
    test_output_backpressure();

    wait_drained();
    repeat (8) @(posedge clk);
    fail_count += expected_results.size();
    $display("ran %0d requests, checked %0d results, capacity log2 0 to 7, four idle mixes",
             requests_sent, results_checked);
    $display("statuses: ok %0d, full %0d, empty %0d, bad index %0d, plus a 60-cycle output stall",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (fail_count == 0) begin
      $display("ring_fifo_with_peek_test: PASS");
    end else begin
      $display("ring_fifo_with_peek_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rfp_pkg.sv
rtl/rfp_mem.sv
rtl/rfp_ctrl.sv
rtl/rfp_resp.sv
rtl/ring_fifo_with_peek.sv
sim/ring_fifo_with_peek_test.sv
